/* hdl/okl_pkg.sv */
// Constants, types and helper functions for the linear RGB to Oklab converter.
// Used by okl_cbrt_lane and rgb_to_oklab_converter_unit; depends on nothing.
`default_nettype none

package okl_pkg;

    localparam int FRAC_BITS = 14;
    localparam int OUT_SHIFT = 40 - FRAC_BITS;

    localparam int PIX_W  = 8;
    localparam int KL_W   = 22;
    localparam int LMS_W  = 31;
    localparam int CN_W   = 61;
    localparam int ROOT_W = 21;
    localparam int B_W    = 46;
    localparam int NSTEP  = 21;
    localparam int KA_W   = 23;
    localparam int PROD_W = 45;
    localparam int ACC_W  = 47;

    localparam int L_W  = 15;
    localparam int AB_W = 16;

    localparam logic [63:0] LMS_DEN = 64'd2550000000000;
    localparam logic [63:0] LAB_DEN = 64'd10000000000;

    typedef struct packed {
        logic [CN_W-1:0]   rem;
        logic [ROOT_W-1:0] root;
    } cbrt_t;

    function automatic logic [KL_W-1:0] lms_k(input logic [63:0] c);
        logic [63:0] q;
        q = (c * 64'd1073741824 + (LMS_DEN >> 1)) / LMS_DEN;
        return q[KL_W-1:0];
    endfunction

    function automatic logic signed [KA_W-1:0] lab_k(input logic [63:0] c);
        logic [63:0] q;
        q = (c * 64'd1048576 + (LAB_DEN >> 1)) / LAB_DEN;
        return $signed(q[KA_W-1:0]);
    endfunction

    localparam logic [KL_W-1:0] LMS_K [3][3] = '{
        '{lms_k(64'd4122214708), lms_k(64'd5363325363), lms_k(64'd514459929)},
        '{lms_k(64'd2119034982), lms_k(64'd6806995451), lms_k(64'd1073969566)},
        '{lms_k(64'd883024619),  lms_k(64'd2817188376), lms_k(64'd6299787005)}
    };

    localparam logic signed [KA_W-1:0] LAB_K [3][3] = '{
        '{lab_k(64'd2104542553),  lab_k(64'd7936177850),   -lab_k(64'd40720468)},
        '{lab_k(64'd19779984951), -lab_k(64'd24285922050), lab_k(64'd4505937099)},
        '{lab_k(64'd259040371),   lab_k(64'd7827717662),   -lab_k(64'd8086757660)}
    };

    // One digit of the restoring binary cube root at bit group s.
    function automatic cbrt_t cbrt_step(input cbrt_t cur, input int s);
        cbrt_t             nxt;
        logic [ROOT_W-1:0] y2;
        logic [B_W-1:0]    prod;
        logic [B_W-1:0]    b;
        logic [CN_W-1:0]   top;
        y2   = {cur.root[ROOT_W-2:0], 1'b0};
        prod = B_W'(y2) * B_W'({1'b0, y2} + 22'd1);
        b    = (prod << 1) + prod + B_W'(1);
        top  = cur.rem >> s;
        nxt  = cur;
        nxt.root = y2;
        if (top >= CN_W'(b)) begin
            nxt.rem  = cur.rem - (CN_W'(b) << s);
            nxt.root = y2 | ROOT_W'(1);
        end
        return nxt;
    endfunction

endpackage

`default_nettype wire

/* hdl/rgb_to_oklab_converter_unit.sv */
// Top level of the linear RGB to Oklab converter: RGB to LMS, cube root, LMS to Lab.
// Depends on okl_pkg and okl_cbrt_lane.
`default_nettype none

// The converter takes one linear RGB pixel per beat and returns Oklab L in unsigned
// Q1.14 and a and b in signed Q2.14, rounded and saturated. It accepts a beat in every
// cycle while in_ready is high; each pixel passes through the RGB to LMS matrix register,
// the digit-by-digit cube root stages, the Lab product register and the sum, rounding
// and output register. Each stage holds its beat when the stage after it is full and stalled.

module rgb_to_oklab_converter_unit
    import okl_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [PIX_W-1:0]       red,
    input  wire logic [PIX_W-1:0]       green,
    input  wire logic [PIX_W-1:0]       blue,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic      [L_W-1:0]         lightness,
    output logic signed [AB_W-1:0]      green_red_axis,
    output logic signed [AB_W-1:0]      blue_yellow_axis
);

    localparam int NST   = NSTEP + 3;
    localparam int ST_PR = NSTEP + 1;

    logic [NST-1:0] valid_reg;
    logic [NST-1:0] valid_next;
    logic [NST:0]   load;

    logic [LMS_W-1:0]         lms_reg  [3];
    logic [LMS_W-1:0]         lms_next [3];
    logic [ROOT_W-1:0]        root     [3];
    logic signed [PROD_W-1:0] prod_reg  [3][3];
    logic signed [PROD_W-1:0] prod_next [3][3];
    logic [L_W-1:0]           l_reg,  l_next;
    logic signed [AB_W-1:0]   a_reg,  a_next;
    logic signed [AB_W-1:0]   b_reg,  b_next;
    logic [PIX_W-1:0]         px [3];

    assign load[NST] = out_ready;
    for (genvar k = 0; k < NST; k++) begin : g_flow
        assign load[k] = !valid_reg[k] || load[k+1];
    end

    always_comb
    begin
        valid_next[0] = in_valid;
        for (int k = 1; k < NST; k++)
        begin
            valid_next[k] = valid_reg[k-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NST; k++)
            begin
                if (load[k])
                begin
                    valid_reg[k] <= valid_next[k];
                end
            end
        end
    end

    assign in_ready = load[0];

    assign px[0] = red;
    assign px[1] = green;
    assign px[2] = blue;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            lms_next[i] = '0;
            for (int j = 0; j < 3; j++)
            begin
                lms_next[i] = lms_next[i]
                            + LMS_W'(LMS_K[i][j] * (KL_W + PIX_W)'(px[j]));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            lms_reg <= lms_next;
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_lane
        okl_cbrt_lane u_cbrt (
            .clk      (clk),
            .en       (load[NSTEP:1]),
            .radicand (lms_reg[i]),
            .root     (root[i])
        );
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                prod_next[i][j] = PROD_W'(PROD_W'(LAB_K[i][j])
                                * $signed(PROD_W'({1'b0, root[j]})));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[ST_PR])
        begin
            prod_reg <= prod_next;
        end
    end

    always_comb
    begin
        logic signed [ACC_W-1:0] acc;
        logic signed [ACC_W-1:0] q;
        l_next = '0;
        a_next = '0;
        b_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            acc = ACC_W'(prod_reg[i][0]) + ACC_W'(prod_reg[i][1]) + ACC_W'(prod_reg[i][2]);
            q   = (acc + (ACC_W'(1) <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT;
            if (i == 0)
            begin
                if (q < 0)
                    l_next = '0;
                else if (q > ACC_W'(32767))
                    l_next = L_W'(32767);
                else
                    l_next = q[L_W-1:0];
            end
            else
            begin
                logic signed [AB_W-1:0] v;
                if (q < -ACC_W'(32768))
                    v = AB_W'(-32768);
                else if (q > ACC_W'(32767))
                    v = AB_W'(32767);
                else
                    v = q[AB_W-1:0];
                if (i == 1)
                    a_next = v;
                else
                    b_next = v;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[NST-1])
        begin
            l_reg <= l_next;
            a_reg <= a_next;
            b_reg <= b_next;
        end
    end

    assign out_valid        = valid_reg[NST-1];
    assign lightness        = l_reg;
    assign green_red_axis   = a_reg;
    assign blue_yellow_axis = b_reg;

endmodule

`default_nettype wire

/* hdl/okl_cbrt_lane.sv */
// One lane of the pipelined integer cube root, one result bit per stage.
// Depends on okl_pkg; stage loads are driven by the top level's flow control.
`default_nettype none

module okl_cbrt_lane
    import okl_pkg::*;
(
    input  wire logic              clk,
    input  wire logic [NSTEP-1:0]  en,
    input  wire logic [LMS_W-1:0]  radicand,
    output logic      [ROOT_W-1:0] root
);

    cbrt_t stage_reg [NSTEP];

    for (genvar k = 0; k < NSTEP; k++) begin : g_step
        cbrt_t cur;
        cbrt_t stage_next;

        if (k == 0) begin : g_first
            assign cur.rem  = {radicand, 30'b0};
            assign cur.root = '0;
        end else begin : g_rest
            assign cur = stage_reg[k-1];
        end

        always_comb
        begin
            stage_next = cbrt_step(cur, 60 - 3 * k);
        end

        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                stage_reg[k] <= stage_next;
            end
        end
    end

    assign root = stage_reg[NSTEP-1].root;

endmodule

`default_nettype wire
